[rtl/aead_pkg.sv]
package aead_pkg;

	localparam logic [1:0] OP_AD     = 2'd0;
	localparam logic [1:0] OP_MSG    = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	localparam logic [1:0] CFG_KEY_HIGH   = 2'd0;
	localparam logic [1:0] CFG_KEY_LOW    = 2'd1;
	localparam logic [1:0] CFG_NONCE_TOP  = 2'd2;
	localparam logic [1:0] CFG_NONCE_REST = 2'd3;

	localparam logic KIND_CT  = 1'b0;
	localparam logic KIND_TAG = 1'b1;

	localparam logic [63:0] AD_CTR_INIT = 64'h0000_0000_6000_0001;
	localparam logic [63:0] CT_CTR_INIT = 64'h0000_0000_4000_0001;

	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [1:0]   op;
		logic [127:0] data;
		logic [127:0] mask;
		logic [127:0] ctr_a;
		logic [127:0] ctr_b;
	} job_t;

	typedef logic [7:0] sbox_t [256];
	localparam sbox_t SBOX = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// one AES round: sub bytes, shift rows, optional mix columns
	function automatic logic [127:0] aes_round(input logic [127:0] st, input logic mix);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] r;
		for (int i = 0; i < 16; i++) s[i] = SBOX[st[127-8*i -: 8]];
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++) t[i+4*c] = s[i + 4*((c+i)%4)];
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
			al = a0 ^ a1 ^ a2 ^ a3;
			if (mix) begin
				s[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
				s[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
				s[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
				s[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
			end else begin
				s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
			end
		end
		for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
		return r;
	endfunction

	// next round key from previous one
	function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		{w0, w1, w2, w3} = k;
		t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
		w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	function automatic logic [31:0] swap32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	// counter step: low word little endian, carry into bytes 11..0
	function automatic logic [127:0] ctr_step(input logic [127:0] c);
		logic [31:0] w;
		logic [95:0] top;
		w = swap32(c[31:0]) + 32'd1;
		top = c[127:32];
		if (w == 32'd0) top = top + 96'd1;
		return {top, swap32(w)};
	endfunction

endpackage

[rtl/aead_if.sv]
interface aead_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [63:0] data_high;
	logic [63:0] data_low;
	logic [4:0] byte_count;
	modport source (output valid, op, data_high, data_low, byte_count, input ready);
	modport sink (input valid, op, data_high, data_low, byte_count, output ready);
endinterface

interface aead_out_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [63:0] out_high;
	logic [63:0] out_low;
	modport source (output valid, kind, out_high, out_low, input ready);
	modport sink (input valid, kind, out_high, out_low, output ready);
endinterface

[rtl/aes128_ctr_xor_tag_aead_top.sv]
// AES-128 counter-mode encryption with XOR tag. Each transaction is one 16-byte
// block: associated data (folded into the tag, no result), message (one
// ciphertext result), finish (one tag result, then counters and tag rearm) or
// none (accepted and dropped). One iterated round unit computes AES with
// on-the-fly key expansion at one round per cycle, one encryption per
// associated-data or finish block and two per message block; a result
// waits while the previous one is not yet taken. A two-entry job queue decouples
// input acceptance from the round unit; the result register holds one output.
// Configure keys and nonce only while idle.
module aes128_ctr_xor_tag_aead_top (
	input  logic        clk,
	input  logic        arst_n,
	aead_in_if.sink     in_ch,
	aead_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);
	import aead_pkg::*;

	logic job_valid, job_ready;
	job_t job;

	aead_front u_front (
		.clk, .arst_n, .in_ch, .cfg_we, .cfg_index, .cfg_wdata,
		.job_valid, .job_ready, .job
	);

	aead_back u_back (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_wdata,
		.job_valid, .job_ready, .job, .out_ch
	);
endmodule

[rtl/aead_front.sv]
// Accepts transactions, builds masks, assigns counters, queues jobs.
module aead_front (
	input  logic               clk,
	input  logic               arst_n,
	aead_in_if.sink            in_ch,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_wdata,
	output logic               job_valid,
	input  logic               job_ready,
	output aead_pkg::job_t     job
);
	import aead_pkg::*;

	logic [31:0]  nonce_top_q;
	logic [63:0]  nonce_rest_q;
	logic [127:0] msg_ctr_q, ad_ctr_q, ct_ctr_q;
	job_t         q_mem [QDEPTH];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         take;
	logic [4:0]   n;
	logic [127:0] mask;
	logic [127:0] nonce_blk;
	job_t         nj;

	assign in_ch.ready = cnt_q != 2'(QDEPTH);
	assign take = in_ch.valid && in_ch.ready && in_ch.op != OP_NONE;
	assign nonce_blk = {nonce_top_q, nonce_rest_q, 32'd0};

	// byte mask
	always_comb begin
		n = (in_ch.byte_count > 5'd16) ? 5'd16 : in_ch.byte_count;
		for (int i = 0; i < 16; i++) mask[127-8*i -: 8] = (5'(i) < n) ? 8'hff : 8'h00;
		nj.op = in_ch.op;
		nj.data = {in_ch.data_high, in_ch.data_low};
		nj.mask = mask;
		nj.ctr_a = (in_ch.op == OP_AD) ? ad_ctr_q :
			(in_ch.op == OP_MSG) ? msg_ctr_q : nonce_blk;
		nj.ctr_b = ct_ctr_q;
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonce_top_q <= '0;
			nonce_rest_q <= '0;
			msg_ctr_q <= 128'd1;
			ad_ctr_q <= {64'd0, AD_CTR_INIT};
			ct_ctr_q <= {64'd0, CT_CTR_INIT};
		end else if (cfg_we && cfg_index == CFG_NONCE_TOP) begin
			nonce_top_q <= cfg_wdata[31:0];
			msg_ctr_q <= {cfg_wdata[31:0], nonce_rest_q, 32'd1};
		end else if (cfg_we && cfg_index == CFG_NONCE_REST) begin
			nonce_rest_q <= cfg_wdata;
			msg_ctr_q <= {nonce_top_q, cfg_wdata, 32'd1};
		end else if (take) begin
			unique case (in_ch.op)
				OP_AD: ad_ctr_q <= ctr_step(ad_ctr_q);
				OP_MSG: begin
					msg_ctr_q <= ctr_step(msg_ctr_q);
					ct_ctr_q <= ctr_step(ct_ctr_q);
				end
				default: begin
					msg_ctr_q <= {nonce_blk[127:32], 32'd1};
					ad_ctr_q <= {64'd0, AD_CTR_INIT};
					ct_ctr_q <= {64'd0, CT_CTR_INIT};
				end
			endcase
		end
	end

	// job queue
	always_ff @(posedge clk) if (take) q_mem[wr_ptr_q] <= nj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (take) wr_ptr_q <= ~wr_ptr_q;
			if (job_valid && job_ready) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(take) - 2'(job_valid && job_ready);
		end
	end

	assign job_valid = cnt_q != 2'd0;
	assign job = q_mem[rd_ptr_q];

	ap_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QDEPTH)) else $error("queue overflow");
	ap_take_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		take && !(job_valid && job_ready) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue count");
	ap_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!job_valid |-> cnt_q == 2'd0) else $error("queue valid");
endmodule

[rtl/aead_back.sv]
// Runs AES with an iterated round unit, folds the tag, drives results.
module aead_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_wdata,
	input  logic               job_valid,
	output logic               job_ready,
	input  aead_pkg::job_t     job,
	aead_out_if.source         out_ch
);
	import aead_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [127:0] key_q;
	logic [127:0] rk_q, st_q, ct_q, tag_q;
	logic [7:0]   rc_q;
	logic [3:0]   rnd_q;
	logic         pass_q;
	logic [1:0]   state_q;
	job_t         job_q;
	logic [127:0] rnd_out, rk_nx, ks;
	logic         last_rnd;
	logic         res_pend;

	assign res_pend = out_ch.valid && !out_ch.ready;
	assign job_ready = state_q == ST_IDLE;
	assign rk_nx = key_next(rk_q, rc_q);
	assign last_rnd = rnd_q == 4'd10;
	assign rnd_out = aes_round(st_q, !last_rnd) ^ rk_nx;
	assign ks = rnd_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) key_q <= '0;
		else if (cfg_we && cfg_index == CFG_KEY_HIGH) key_q[127:64] <= cfg_wdata;
		else if (cfg_we && cfg_index == CFG_KEY_LOW) key_q[63:0] <= cfg_wdata;
	end

	// round sequencer: 10 rounds per encryption, key schedule on the fly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tag_q <= '0;
			out_ch.valid <= 1'b0;
			rnd_q <= '0;
			pass_q <= 1'b0;
		end else begin
			// result register: load from WAIT, clear once taken
			if (state_q == ST_WAIT && !res_pend) out_ch.valid <= 1'b1;
			else if (out_ch.ready) out_ch.valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (job_valid) begin
					job_q <= job;
					st_q <= job.ctr_a ^ key_q;
					rk_q <= key_q;
					rc_q <= 8'h01;
					rnd_q <= 4'd1;
					pass_q <= 1'b0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (!last_rnd) begin
						st_q <= rnd_out;
						rk_q <= rk_nx;
						rc_q <= xtime(rc_q);
						rnd_q <= rnd_q + 4'd1;
					end else if (job_q.op == OP_MSG && !pass_q) begin
						ct_q <= (job_q.data ^ ks) & job_q.mask;
						st_q <= job_q.ctr_b ^ key_q;
						rk_q <= key_q;
						rc_q <= 8'h01;
						rnd_q <= 4'd1;
						pass_q <= 1'b1;
					end else if (job_q.op == OP_AD) begin
						tag_q <= tag_q ^ ((ks ^ job_q.data) & job_q.mask);
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_WAIT;
						st_q <= ks;
					end
				end
				ST_WAIT: if (!res_pend) begin
					if (job_q.op == OP_MSG) begin
						out_ch.kind <= KIND_CT;
						{out_ch.out_high, out_ch.out_low} <= ct_q;
						tag_q <= tag_q ^ ((st_q ^ ct_q) & job_q.mask);
					end else begin
						out_ch.kind <= KIND_TAG;
						{out_ch.out_high, out_ch.out_low} <= tag_q ^ st_q;
						tag_q <= '0;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	ap_rnd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> rnd_q >= 4'd1 && rnd_q <= 4'd10) else $error("round count");
	ap_pass: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && pass_q |-> job_q.op == OP_MSG) else $error("second pass");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.out_low))
		else $error("result dropped");
endmodule

[sim/aes128_ctr_xor_tag_aead_top_tb.sv]
module aes128_ctr_xor_tag_aead_top_tb;
	import aead_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [1:0]  op;
		logic [63:0] dh;
		logic [63:0] dl;
		logic [4:0]  bc;
	} block_t;

	typedef struct {
		logic        kind;
		logic [63:0] hi;
		logic [63:0] lo;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_wdata;

	aead_in_if  in_ch ();
	aead_out_if out_ch ();

	aes128_ctr_xor_tag_aead_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	block_t  block_q[$];
	result_t result_q[$];
	int      errors;
	int      in_gap;
	int      out_gap;
	int      stuck_cycles;
	bit      in_fire;
	bit      calm;

	// shadow of the block's configuration and state
	logic [127:0] key;
	logic [31:0]  nonce_top;
	logic [63:0]  nonce_rest;
	logic [127:0] tag_acc;
	logic [127:0] msg_ctr;
	logic [127:0] ad_ctr;
	logic [127:0] ct_ctr;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [7:0] gf_double(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// plain AES-128 encryption, key schedule computed round by round
	function automatic logic [127:0] aes_encrypt(input logic [127:0] k, input logic [127:0] pt);
		logic [127:0] st;
		logic [127:0] rk;
		logic [7:0]   s [16];
		logic [7:0]   t [16];
		logic [7:0]   rc;
		logic [7:0]   all;
		logic [31:0]  w0, w1, w2, w3, g;
		rk = k;
		rc = 8'h01;
		st = pt ^ rk;
		for (int r = 1; r <= 10; r++) begin
			for (int i = 0; i < 16; i++) s[i] = SBOX[st[127-8*i -: 8]];
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++) t[i+4*c] = s[i + 4*((c+i)%4)];
			for (int c = 0; c < 4; c++) begin
				if (r < 10) begin
					all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
					s[4*c]   = t[4*c]   ^ all ^ gf_double(t[4*c]   ^ t[4*c+1]);
					s[4*c+1] = t[4*c+1] ^ all ^ gf_double(t[4*c+1] ^ t[4*c+2]);
					s[4*c+2] = t[4*c+2] ^ all ^ gf_double(t[4*c+2] ^ t[4*c+3]);
					s[4*c+3] = t[4*c+3] ^ all ^ gf_double(t[4*c+3] ^ t[4*c]);
				end else begin
					for (int i = 0; i < 4; i++) s[4*c+i] = t[4*c+i];
				end
			end
			for (int i = 0; i < 16; i++) st[127-8*i -: 8] = s[i];
			{w0, w1, w2, w3} = rk;
			g = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
			w0 = w0 ^ g;
			w1 = w1 ^ w0;
			w2 = w2 ^ w1;
			w3 = w3 ^ w2;
			rk = {w0, w1, w2, w3};
			rc = gf_double(rc);
			st = st ^ rk;
		end
		return st;
	endfunction

	// low word counts little endian, wrap carries into bytes 11..0
	function automatic logic [127:0] bump(input logic [127:0] c);
		logic [31:0] w;
		logic [95:0] upper;
		w = {c[7:0], c[15:8], c[23:16], c[31:24]} + 32'd1;
		upper = c[127:32];
		if (w == 32'd0) upper = upper + 96'd1;
		return {upper, w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	function automatic logic [127:0] lead_mask(input logic [4:0] bc);
		int n;
		n = (bc > 5'd16) ? 16 : bc;
		return (n == 0) ? 128'd0 : ({128{1'b1}} << (128 - 8*n));
	endfunction

	task automatic rearm();
		tag_acc = '0;
		msg_ctr = {nonce_top, nonce_rest, 32'h0000_0001};
		ad_ctr  = {64'd0, AD_CTR_INIT};
		ct_ctr  = {64'd0, CT_CTR_INIT};
	endtask

	// expected result of one accepted block, state advanced
	task automatic predict_block(input block_t b);
		logic [127:0] m, d, ks, ct;
		result_t r;
		m = lead_mask(b.bc);
		d = {b.dh, b.dl};
		case (b.op)
			OP_AD: begin
				ks = aes_encrypt(key, ad_ctr);
				tag_acc = tag_acc ^ ((ks ^ d) & m);
				ad_ctr = bump(ad_ctr);
			end
			OP_MSG: begin
				ks = aes_encrypt(key, msg_ctr);
				ct = (ks ^ d) & m;
				msg_ctr = bump(msg_ctr);
				ks = aes_encrypt(key, ct_ctr);
				tag_acc = tag_acc ^ ((ks ^ ct) & m);
				ct_ctr = bump(ct_ctr);
				r.kind = KIND_CT;
				{r.hi, r.lo} = ct;
				result_q.push_back(r);
			end
			OP_FINISH: begin
				ks = aes_encrypt(key, {nonce_top, nonce_rest, 32'd0});
				r.kind = KIND_TAG;
				{r.hi, r.lo} = tag_acc ^ ks;
				result_q.push_back(r);
				rearm();
			end
			default: ;
		endcase
	endtask

	// sampling, checking and watchdog
	always @(posedge clk) begin
		result_t e;
		in_fire = in_ch.valid && in_ch.ready;
		if (in_fire)
			predict_block('{in_ch.op, in_ch.data_high, in_ch.data_low, in_ch.byte_count});
		if (out_ch.valid && out_ch.ready) begin
			if (result_q.size() == 0) begin
				$error("unexpected result transaction kind=%0d", out_ch.kind);
				errors++;
			end else begin
				e = result_q.pop_front();
				if (out_ch.kind !== e.kind) begin
					$error("kind: expected %0d, actual %0d", e.kind, out_ch.kind);
					errors++;
				end
				if (out_ch.out_high !== e.hi) begin
					$error("out_high: expected %h, actual %h", e.hi, out_ch.out_high);
					errors++;
				end
				if (out_ch.out_low !== e.lo) begin
					$error("out_low: expected %h, actual %h", e.lo, out_ch.out_low);
					errors++;
				end
			end
		end
		if (in_fire || (out_ch.valid && out_ch.ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= 3000) begin
			$display("aes128_ctr_xor_tag_aead_top_tb: FAIL");
			$finish;
		end
	end

	// input driver with random bursts of idle
	always @(negedge clk) begin
		block_t b;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (in_ch.valid && !in_fire) begin
			// hold the pending transaction
		end else if (in_gap > 0) begin
			in_gap--;
			in_ch.valid <= 1'b0;
		end else if (block_q.size() > 0) begin
			b = block_q.pop_front();
			in_ch.op         <= b.op;
			in_ch.data_high  <= b.dh;
			in_ch.data_low   <= b.dl;
			in_ch.byte_count <= b.bc;
			in_ch.valid      <= 1'b1;
			if (!calm && $urandom_range(0, 6) == 0) in_gap = $urandom_range(1, 15);
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
			if (!calm && $urandom_range(0, 6) == 0) out_gap = $urandom_range(1, 15);
		end
	end

	task automatic add_block(input logic [1:0] op, input logic [63:0] dh, input logic [63:0] dl,
			input logic [4:0] bc);
		block_q.push_back('{op, dh, dl, bc});
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_KEY_HIGH:   key[127:64] = val;
			CFG_KEY_LOW:    key[63:0] = val;
			CFG_NONCE_TOP: begin
				nonce_top = val[31:0];
				msg_ctr = {nonce_top, nonce_rest, 32'h0000_0001};
			end
			default: begin
				nonce_rest = val;
				msg_ctr = {nonce_top, nonce_rest, 32'h0000_0001};
			end
		endcase
	endtask

	// drain everything, then let a block that yields no result settle
	task automatic wait_drained();
		while (block_q.size() > 0 || in_ch.valid || result_q.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// mostly well-formed messages with random content, some noise
	task automatic random_traffic(input int count);
		int n_ad, n_msg, added;
		added = 0;
		while (added < count) begin
			if ($urandom_range(0, 9) == 0) begin
				add_block(2'($urandom_range(0, 3)), rand64(), rand64(),
					5'($urandom_range(0, 31)));
				added++;
			end else begin
				n_ad  = $urandom_range(0, 3);
				n_msg = $urandom_range(0, 6);
				for (int i = 0; i < n_ad; i++)
					add_block(OP_AD, rand64(), rand64(),
						(i == n_ad - 1) ? 5'($urandom_range(1, 16)) : 5'd16);
				for (int i = 0; i < n_msg; i++)
					add_block(OP_MSG, rand64(), rand64(),
						(i == n_msg - 1) ? 5'($urandom_range(1, 16)) : 5'd16);
				add_block(OP_FINISH, rand64(), rand64(), 5'($urandom_range(1, 16)));
				added += n_ad + n_msg + 1;
			end
		end
	endtask

	initial begin
		logic [63:0] ones;
		ones = {64{1'b1}};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_KEY_HIGH;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.op = OP_AD;
		in_ch.data_high = '0;
		in_ch.data_low = '0;
		in_ch.byte_count = 5'd16;
		out_ch.ready = 1'b0;
		errors = 0;
		in_gap = 0;
		out_gap = 0;
		stuck_cycles = 0;
		calm = 1'b0;
		key = '0;
		nonce_top = '0;
		nonce_rest = '0;
		rearm();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed part under the reset key and nonce
		add_block(OP_AD, 64'd0, 64'd0, 5'd16);
		add_block(OP_AD, ones, ones, 5'd5);
		add_block(OP_AD, ones, ones, 5'd0);
		add_block(OP_MSG, ones, ones, 5'd16);
		add_block(OP_MSG, 64'd0, 64'd0, 5'd16);
		add_block(OP_MSG, ones, ones, 5'd1);
		add_block(OP_MSG, ones, ones, 5'd8);
		add_block(OP_MSG, ones, ones, 5'd9);
		add_block(OP_MSG, ones, ones, 5'd0);
		add_block(OP_MSG, ones, ones, 5'd17);
		add_block(OP_MSG, ones, ones, 5'd31);
		add_block(OP_NONE, ones, ones, 5'd16);
		add_block(OP_FINISH, ones, ones, 5'd0);
		add_block(OP_FINISH, 64'd0, 64'd0, 5'd16);
		add_block(OP_AD, rand64(), rand64(), 5'd15);
		add_block(OP_MSG, rand64(), rand64(), 5'd16);
		add_block(OP_NONE, 64'd0, 64'd0, 5'd0);
		add_block(OP_FINISH, rand64(), rand64(), 5'd31);
		wait_drained();

		// all-ones key and nonce
		write_reg(CFG_KEY_HIGH, ones);
		write_reg(CFG_KEY_LOW, ones);
		write_reg(CFG_NONCE_TOP, {32'd0, 32'hffff_ffff});
		write_reg(CFG_NONCE_REST, ones);
		random_traffic(230);
		wait_drained();

		// nonce change in the middle of a message keeps the tag
		add_block(OP_AD, rand64(), rand64(), 5'd16);
		add_block(OP_MSG, rand64(), rand64(), 5'd16);
		wait_drained();
		write_reg(CFG_NONCE_REST, rand64());
		add_block(OP_MSG, rand64(), rand64(), 5'd16);
		wait_drained();
		write_reg(CFG_KEY_LOW, rand64());
		add_block(OP_MSG, rand64(), rand64(), 5'd7);
		add_block(OP_FINISH, rand64(), rand64(), 5'd16);
		wait_drained();

		for (int p = 0; p < 6; p++) begin
			write_reg(CFG_KEY_HIGH, rand64());
			write_reg(CFG_KEY_LOW, rand64());
			write_reg(CFG_NONCE_TOP, rand64());
			write_reg(CFG_NONCE_REST, rand64());
			if (p == 5) calm = 1'b1;
			random_traffic(255);
			wait_drained();
		end

		if (errors == 0)
			$display("aes128_ctr_xor_tag_aead_top_tb: PASS");
		else
			$display("aes128_ctr_xor_tag_aead_top_tb: FAIL");
		$finish;
	end

endmodule

[files.f]
rtl/aead_pkg.sv
rtl/aead_if.sv
rtl/aead_front.sv
rtl/aead_back.sv
rtl/aes128_ctr_xor_tag_aead_top.sv
sim/aes128_ctr_xor_tag_aead_top_tb.sv
